// ----- rtl/core/sorted_list_engine_macros.svh -----
// assertion macros for the sorted list engine checker
`ifndef SORTED_LIST_ENGINE_MACROS_SVH
`define SORTED_LIST_ENGINE_MACROS_SVH

// same-cycle implication, disabled during reset
`define SLE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/sle_pkg.sv -----
package sle_pkg;

  // default list depth
  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_DUMP   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // which entry the datapath reads, relative to the pointer
  typedef enum logic [1:0] {
    RD_PREV = 2'd0,
    RD_CUR  = 2'd1,
    RD_NEXT = 2'd2
  } rd_sel_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       load;         // capture value, set pointer
    logic       load_top;     // pointer starts at count, else at zero
    logic       rd_en;
    rd_sel_t    rd_sel;
    logic       wr_en;
    logic       wr_value;     // write captured value, else read data
    logic       ptr_inc;
    logic       ptr_dec;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       emit;
    logic [1:0] emit_status;
    logic       emit_elem;    // element from read data, else zero
    logic       emit_last;
  } sle_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic ptr_zero;
    logic ptr_at_end;
    logic ptr_penult;
    logic rd_ge;
    logic rd_eq;
  } sle_sts_t;

endpackage

// ----- rtl/core/sle_datapath.sv -----
module sle_datapath
  import sle_pkg::*;
#(
  parameter int  DEPTH = DEPTH_DEF,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic signed [DATA_W-1:0] value,
  input  sle_cmd_t                 cmd,
  output sle_sts_t                 sts,
  output logic [1:0]               status,
  output logic signed [DATA_W-1:0] element,
  output logic [CW-1:0]            entry_count,
  output logic                     last,
  output logic                     strobe
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] val_r;
  logic [CW-1:0]     ptr;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [CW-1:0]     ptr_prev;
  logic [CW-1:0]     ptr_succ;
  logic [CW-1:0]     rd_ptr;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;

  // pointer neighbors and address selection
  assign ptr_prev = ptr - CW'(1);
  assign ptr_succ = ptr + CW'(1);

  always_comb begin
    unique case (cmd.rd_sel)
      RD_PREV: rd_ptr = ptr_prev;
      RD_NEXT: rd_ptr = ptr_succ;
      default: rd_ptr = ptr;
    endcase
  end

  assign rd_addr = rd_ptr[AW-1:0];
  assign wr_addr = ptr[AW-1:0];
  assign wr_data = cmd.wr_value ? val_r : rd_data;

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // entry count after this cycle
  always_comb begin
    count_next = count;
    if (cmd.cnt_inc) begin
      count_next = count + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_next = count - CW'(1);
    end
  end

  // count and pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ptr   <= '0;
    end else begin
      count <= count_next;
      if (cmd.load) begin
        ptr <= cmd.load_top ? count : '0;
      end else if (cmd.ptr_inc) begin
        ptr <= ptr_succ;
      end else if (cmd.ptr_dec) begin
        ptr <= ptr_prev;
      end
    end
  end

  // operand capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r <= value;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status      <= cmd.emit_status;
      element     <= cmd.emit_elem ? rd_data : '0;
      entry_count <= count_next;
      last        <= cmd.emit_last;
    end
  end

  // status flags for the controller
  always_comb begin
    sts.full       = (count == CW'(DEPTH));
    sts.empty      = (count == '0);
    sts.ptr_zero   = (ptr == '0);
    sts.ptr_at_end = (ptr == count);
    sts.ptr_penult = (ptr_succ == count);
    sts.rd_ge      = ($signed(rd_data) >= $signed(val_r));
    sts.rd_eq      = (rd_data == val_r);
  end

endmodule

// ----- rtl/core/sle_controller.sv -----
module sle_controller
  import sle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] op,
  input  sle_sts_t   sts,
  output sle_cmd_t   cmd,
  output logic       busy
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_INS_RD  = 9'b000000010,
    S_INS_CMP = 9'b000000100,
    S_DEL_RD  = 9'b000001000,
    S_DEL_CMP = 9'b000010000,
    S_SH_RD   = 9'b000100000,
    S_SH_WR   = 9'b001000000,
    S_DMP_RD  = 9'b010000000,
    S_DMP_OUT = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencing of insert, delete and dump
  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_CUR;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          case (op)
            OP_INSERT: begin
              if (sts.full) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_FULL;
                cmd.emit_last   = 1'b1;
              end else begin
                cmd.load     = 1'b1;
                cmd.load_top = 1'b1;
                state_next   = S_INS_RD;
              end
            end
            OP_DELETE: begin
              if (sts.empty) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_NOT_FOUND;
                cmd.emit_last   = 1'b1;
              end else begin
                cmd.load   = 1'b1;
                state_next = S_DEL_RD;
              end
            end
            OP_DUMP: begin
              if (sts.empty) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_EMPTY;
                cmd.emit_last   = 1'b1;
              end else begin
                cmd.load   = 1'b1;
                state_next = S_DMP_RD;
              end
            end
            default: begin
              // unused code, dropped
            end
          endcase
        end
      end
      // insert: walk down from the top, shifting larger-or-equal entries up
      S_INS_RD: begin
        if (sts.ptr_zero) begin
          cmd.wr_en       = 1'b1;
          cmd.wr_value    = 1'b1;
          cmd.cnt_inc     = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_OK;
          cmd.emit_last   = 1'b1;
          state_next      = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PREV;
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        cmd.wr_en = 1'b1;
        if (sts.rd_ge) begin
          cmd.ptr_dec = 1'b1;
          state_next  = S_INS_RD;
        end else begin
          cmd.wr_value    = 1'b1;
          cmd.cnt_inc     = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_OK;
          cmd.emit_last   = 1'b1;
          state_next      = S_IDLE;
        end
      end
      // delete: search from the head for the first equal entry
      S_DEL_RD: begin
        if (sts.ptr_at_end) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_NOT_FOUND;
          cmd.emit_last   = 1'b1;
          state_next      = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_DEL_CMP;
        end
      end
      S_DEL_CMP: begin
        if (sts.rd_eq) begin
          state_next = S_SH_RD;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_next  = S_DEL_RD;
        end
      end
      // close the gap by moving later entries down one place
      S_SH_RD: begin
        if (sts.ptr_penult) begin
          cmd.cnt_dec     = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_OK;
          cmd.emit_last   = 1'b1;
          state_next      = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEXT;
          state_next = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.ptr_inc = 1'b1;
        state_next  = S_SH_RD;
      end
      // dump: read each entry, then emit it
      S_DMP_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_DMP_OUT;
      end
      S_DMP_OUT: begin
        cmd.emit        = 1'b1;
        cmd.emit_status = ST_OK;
        cmd.emit_elem   = 1'b1;
        cmd.emit_last   = sts.ptr_penult;
        cmd.ptr_inc     = 1'b1;
        state_next      = sts.ptr_penult ? S_IDLE : S_DMP_RD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/sorted_list_engine.sv -----
// Sorted list of up to DEPTH signed 32-bit values kept in ascending order in an
// entry memory with a registered read, used for one access a cycle at most. An
// operation is taken when start is high and busy is low; busy drops at the edge
// that puts its last result on the ports. An insert walks down from the top,
// moving each larger-or-equal entry up; a delete searches from the head for a
// match and then moves later entries down; a dump reads each entry before it
// emits its beat. A full insert, a delete from an empty list and an empty dump
// answer without busy rising, and op code 3 is taken and dropped without a
// result. Every result is held on the result ports for exactly one cycle with
// strobe high and cannot be stalled, so the receiver must take each beat as it
// comes; last marks an operation's final beat. No memory clearing runs after
// reset: only stored entries are read.
module sorted_list_engine
  import sle_pkg::*;
#(
  parameter int  DEPTH = DEPTH_DEF,
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               op,
  input  logic signed [DATA_W-1:0] value,
  output logic                     strobe,
  output logic [1:0]               status,
  output logic signed [DATA_W-1:0] element,
  output logic [CW-1:0]            entry_count,
  output logic                     last
);

  sle_cmd_t cmd;
  sle_sts_t sts;

  // sequencer
  sle_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // entry memory, count and result register
  sle_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .value       (value),
    .cmd         (cmd),
    .sts         (sts),
    .status      (status),
    .element     (element),
    .entry_count (entry_count),
    .last        (last),
    .strobe      (strobe)
  );

endmodule

// ----- rtl/core/sle_checker.sv -----
`include "sorted_list_engine_macros.svh"

module sle_checker
  import sle_pkg::*;
#(
  parameter int  DEPTH = DEPTH_DEF,
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     busy,
  input logic                     strobe,
  input logic [1:0]               status,
  input logic signed [DATA_W-1:0] element,
  input logic [CW-1:0]            entry_count,
  input logic                     last
);

  // a beat that is not the last belongs to a dump still running
  `SLE_ASSERT_NOW(a_mid_beat_busy, clk, rst, strobe && !last, busy && (status == ST_OK), "non-final beat while idle or not ok")

  // count never goes past the depth
  `SLE_ASSERT_NOW(a_count_bound, clk, rst, strobe, entry_count <= CW'(DEPTH), "entry count beyond depth")

  // full is only reported with every entry in use
  `SLE_ASSERT_NOW(a_full_count, clk, rst, strobe && (status == ST_FULL), (entry_count == CW'(DEPTH)) && last, "full reported with room left")

  // empty dump is one final beat with no element
  `SLE_ASSERT_NOW(a_empty_beat, clk, rst, strobe && (status == ST_EMPTY), (entry_count == '0) && last && (element == '0), "malformed empty beat")

endmodule

bind sorted_list_engine sle_checker #(
  .DEPTH (DEPTH)
) u_sle_checker (
  .clk         (clk),
  .rst         (rst),
  .busy        (busy),
  .strobe      (strobe),
  .status      (status),
  .element     (element),
  .entry_count (entry_count),
  .last        (last)
);
